FILE: src/ni_vc_allocate_and_schedule_assert.svh
// assertion macros shared by the vc allocator modules
// no dependencies; included by the controller and the datapath
`ifndef NI_VC_ALLOCATE_AND_SCHEDULE_ASSERT_SVH
`define NI_VC_ALLOCATE_AND_SCHEDULE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/nivc_pkg.sv
// shared constants, widths, request and channel codes, and the controller-to-datapath command
// no dependencies
package nivc_pkg;

   localparam int NUM_VNETS_DEF    = 4;
   localparam int VCS_PER_VNET_DEF = 4;

   localparam int VNET_IN_W   = 2;
   localparam int VC_IDX_W    = 4;
   localparam int MASK_W      = 16;
   localparam int CFG_W       = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_GRANT   = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_SCHED   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {CH_IDLE, CH_WAIT, CH_ACTIVE} ch_state_type;

   typedef struct packed {
      logic load_req;
      logic commit;
   } nivc_cmd_type;

endpackage

FILE: src/nivc_ctrl.sv
// controller: input register occupancy, commit timing and response valid
// depends on nivc_pkg and the assertion macro header
`include "ni_vc_allocate_and_schedule_assert.svh"

module nivc_ctrl
   import nivc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output nivc_cmd_type cmd
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free       = !rsp_valid_ff || rsp_tready;
      cmd.commit     = (state_ff == ST_EXEC) && out_free;
      req_tready     = !reset && ((state_ff == ST_IDLE) || cmd.commit);
      cmd.load_req   = req_tvalid && req_tready;

      case (state_ff)
         ST_IDLE: state_in = cmd.load_req ? ST_EXEC : ST_IDLE;
         ST_EXEC: begin
            // stay while the output register is still occupied
            if (!cmd.commit) state_in = ST_EXEC;
            else state_in = cmd.load_req ? ST_EXEC : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_IMPLIES(a_commit_in_exec, clock, reset, cmd.commit, state_ff == ST_EXEC)
   `ASSERT_NEXT(a_commit_fills_out, clock, reset, cmd.commit, rsp_valid_ff)
   `ASSERT_NEXT(a_load_goes_exec, clock, reset, cmd.load_req, state_ff == ST_EXEC)

endmodule

FILE: src/nivc_dpath.sv
// datapath: request register, vc state table, round-robin pointers,
// allocate and schedule search, response register; depends on nivc_pkg
`include "ni_vc_allocate_and_schedule_assert.svh"

module nivc_dpath
   import nivc_pkg::*;
#(
   parameter int NUM_VNETS    = NUM_VNETS_DEF,
   parameter int VCS_PER_VNET = VCS_PER_VNET_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nivc_cmd_type           cmd,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   csr_wr_en,
   input  logic [CFG_W-1:0]       csr_wr_data,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int TOTAL_VCS = NUM_VNETS * VCS_PER_VNET;
   localparam int VC_W      = (TOTAL_VCS > 1) ? $clog2(TOTAL_VCS) : 1;
   localparam int PTR_W     = (VCS_PER_VNET > 1) ? $clog2(VCS_PER_VNET) : 1;
   localparam int VNET_W    = (NUM_VNETS > 1) ? $clog2(NUM_VNETS) : 1;

   // request register
   req_kind_type           kind_ff;
   logic [VNET_IN_W-1:0]   vnet_ff;
   logic [VC_IDX_W-1:0]    vci_ff;
   logic [MASK_W-1:0]      ready_ff, credit_ff;

   logic [CFG_W-1:0]       ordered_ff;
   ch_state_type           ch_state_ff [TOTAL_VCS];
   ch_state_type           ch_state_in [TOTAL_VCS];
   logic [PTR_W-1:0]       alloc_ptr_ff [NUM_VNETS];
   logic [PTR_W-1:0]       alloc_ptr_in [NUM_VNETS];
   logic [VC_W-1:0]        sched_ptr_ff, sched_ptr_in;

   logic [VC_IDX_W-1:0]    chosen_ff, chosen_in;
   logic                   found_ff, found_in;
   logic                   bad_ff, bad_in;

   // allocate search
   logic                   vnet_ok, ord;
   logic [VNET_W-1:0]      vnet_sel;
   logic [VC_W-1:0]        base;
   logic [PTR_W-1:0]       start;
   logic [PTR_W:0]         off_sum [VCS_PER_VNET];
   logic [PTR_W-1:0]       off_k [VCS_PER_VNET];
   logic                   alloc_hit;
   logic [PTR_W-1:0]       alloc_off, alloc_ptr_next;
   logic [VC_W-1:0]        alloc_vc;

   // grant and release
   logic                   vc_ok;
   logic [VC_W-1:0]        vci_sel;
   ch_state_type           need_st, next_st;

   // schedule search
   logic [TOTAL_VCS-1:0]   ready_ext, credit_ext, elig, upper, elig_hi;
   logic                   sched_hit, hi_hit;
   logic [VC_W-1:0]        low_all, low_hi, sched_vc;

   always_comb begin
      // ---- allocate ----
      vnet_ok  = int'(vnet_ff) < NUM_VNETS;
      vnet_sel = vnet_ok ? VNET_W'(vnet_ff) : '0;
      ord      = ordered_ff[vnet_ff];
      base     = VC_W'(int'(vnet_sel) * VCS_PER_VNET);
      start    = alloc_ptr_ff[vnet_sel];
      for (int k = 0; k < VCS_PER_VNET; k++) begin
         off_sum[k] = {1'b0, start} + (PTR_W+1)'(k);
         if (int'(off_sum[k]) >= VCS_PER_VNET)
            off_k[k] = PTR_W'(int'(off_sum[k]) - VCS_PER_VNET);
         else
            off_k[k] = off_sum[k][PTR_W-1:0];
      end
      alloc_hit = 1'b0;
      alloc_off = '0;
      if (ord) begin
         alloc_hit = ch_state_ff[base] == CH_IDLE;
      end else begin
         for (int k = 0; k < VCS_PER_VNET; k++) begin
            if (!alloc_hit && ch_state_ff[VC_W'(base + VC_W'(off_k[k]))] == CH_IDLE) begin
               alloc_hit = 1'b1;
               alloc_off = off_k[k];
            end
         end
      end
      alloc_vc = VC_W'(base + VC_W'(alloc_off));
      // pointer steps once per vc tried; a full miss lands back on start
      if (ord) alloc_ptr_next = '0;
      else if (!alloc_hit) alloc_ptr_next = start;
      else if (int'(alloc_off) == VCS_PER_VNET - 1) alloc_ptr_next = '0;
      else alloc_ptr_next = alloc_off + PTR_W'(1);

      // ---- grant / release ----
      vc_ok   = int'(vci_ff) < TOTAL_VCS;
      vci_sel = vc_ok ? VC_W'(vci_ff) : '0;
      need_st = (kind_ff == REQ_GRANT) ? CH_WAIT : CH_ACTIVE;
      next_st = (kind_ff == REQ_GRANT) ? CH_ACTIVE : CH_IDLE;

      // ---- schedule: rotating priority starting after the old pointer ----
      ready_ext  = TOTAL_VCS'(ready_ff);
      credit_ext = TOTAL_VCS'(credit_ff);
      for (int v = 0; v < TOTAL_VCS; v++) begin
         elig[v]  = ready_ext[v] && credit_ext[v] && (ch_state_ff[v] == CH_ACTIVE);
         upper[v] = v > int'(sched_ptr_ff);
      end
      elig_hi   = elig & upper;
      sched_hit = |elig;
      hi_hit    = |elig_hi;
      low_all   = '0;
      low_hi    = '0;
      for (int v = TOTAL_VCS - 1; v >= 0; v--) begin
         if (elig[v]) low_all = VC_W'(v);
         if (elig_hi[v]) low_hi = VC_W'(v);
      end
      sched_vc = hi_hit ? low_hi : low_all;

      // ---- next state ----
      ch_state_in  = ch_state_ff;
      alloc_ptr_in = alloc_ptr_ff;
      sched_ptr_in = sched_ptr_ff;
      chosen_in    = '0;
      found_in     = 1'b0;
      bad_in       = 1'b0;
      case (kind_ff)
         REQ_ALLOC: begin
            if (vnet_ok) begin
               alloc_ptr_in[vnet_sel] = alloc_ptr_next;
               if (alloc_hit) begin
                  ch_state_in[alloc_vc] = CH_WAIT;
                  chosen_in = VC_IDX_W'(alloc_vc);
                  found_in  = 1'b1;
               end
            end
         end
         REQ_GRANT, REQ_RELEASE: begin
            if (vc_ok && ch_state_ff[vci_sel] == need_st) ch_state_in[vci_sel] = next_st;
            else bad_in = 1'b1;
         end
         REQ_SCHED: begin
            if (int'(sched_ptr_ff) == TOTAL_VCS - 1) sched_ptr_in = '0;
            else sched_ptr_in = sched_ptr_ff + VC_W'(1);
            if (sched_hit) begin
               chosen_in = VC_IDX_W'(sched_vc);
               found_in  = 1'b1;
            end
         end
         default: bad_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ordered_ff   <= '0;
         sched_ptr_ff <= '0;
         for (int v = 0; v < TOTAL_VCS; v++) ch_state_ff[v] <= CH_IDLE;
         for (int n = 0; n < NUM_VNETS; n++) alloc_ptr_ff[n] <= '0;
      end else begin
         if (csr_wr_en) ordered_ff <= csr_wr_data;
         if (cmd.commit) begin
            ch_state_ff  <= ch_state_in;
            alloc_ptr_ff <= alloc_ptr_in;
            sched_ptr_ff <= sched_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff   <= req_kind_type'(req_tuser);
         vnet_ff   <= req_tdata[1:0];
         vci_ff    <= req_tdata[5:2];
         ready_ff  <= req_tdata[21:6];
         credit_ff <= req_tdata[37:22];
      end
      if (cmd.commit) begin
         chosen_ff <= chosen_in;
         found_ff  <= found_in;
         bad_ff    <= bad_in;
      end
   end

   assign rsp_tdata = {(RSP_TDATA_W - VC_IDX_W)'(0), chosen_ff};
   assign rsp_tuser = {bad_ff, found_ff};

   `ASSERT_NEXT(a_alloc_marks_wait, clock, reset,
      cmd.commit && kind_ff == REQ_ALLOC && vnet_ok && alloc_hit,
      ch_state_ff[$past(alloc_vc)] == CH_WAIT)
   `ASSERT_NEXT(a_bad_only_grant_release, clock, reset,
      cmd.commit && (kind_ff == REQ_ALLOC || kind_ff == REQ_SCHED), !bad_ff)
   `ASSERT_IMPLIES(a_sched_ptr_range, clock, reset, 1'b1, int'(sched_ptr_ff) < TOTAL_VCS)

endmodule

FILE: src/ni_vc_allocate_and_schedule.sv
// Output VC allocator and link scheduler. A request is taken into an input
// register and committed once the output register is free, when the per-VC state,
// the per-vnet round-robin pointers and the global schedule pointer update and the
// response register loads; a new request is accepted in the commit cycle, so the
// block sustains one request per cycle while the output is not stalled. The single
// commit stage, which reads and writes the VC state table, sets that rate.
// Responses wait in the output register while the next request is taken.
// depends on nivc_pkg, nivc_ctrl, nivc_dpath

module ni_vc_allocate_and_schedule
   import nivc_pkg::*;
#(
   parameter int NUM_VNETS    = NUM_VNETS_DEF,
   parameter int VCS_PER_VNET = VCS_PER_VNET_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // vnet[1:0], vc_index[5:2], ready_mask[21:6], credit_mask[37:22], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // chosen_vc[3:0], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // found[0], bad_state[1]
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                   csr_wr_en,
   // ordered_vnets
   input  logic [CFG_W-1:0]       csr_wr_data
);

   nivc_cmd_type cmd;

   nivc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   nivc_dpath #(
      .NUM_VNETS    (NUM_VNETS),
      .VCS_PER_VNET (VCS_PER_VNET)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

FILE: sim/ni_vc_allocate_and_schedule_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the output vc allocator and link scheduler: directed and
// random allocate, grant, release and schedule requests checked against a predictor
// depends on nivc_pkg and ni_vc_allocate_and_schedule

module ni_vc_allocate_and_schedule_tb
   import nivc_pkg::*;
();

   localparam int NUM_VCS     = NUM_VNETS_DEF * VCS_PER_VNET_DEF;
   localparam int OFS_W       = $clog2(VCS_PER_VNET_DEF);
   localparam int CHUNK_ITEMS = 288;
   localparam int NUM_CHUNKS  = 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 30;

   typedef struct {
      req_kind_type         kind;
      logic [VNET_IN_W-1:0] vnet;
      logic [VC_IDX_W-1:0]  vc_index;
      logic [MASK_W-1:0]    ready_mask;
      logic [MASK_W-1:0]    credit_mask;
      bit                   hold;  // held back until every response is in
   } vc_req_type;

   typedef struct {
      logic [VC_IDX_W-1:0] chosen_vc;
      logic                found;
      logic                bad_state;
   } vc_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_wr_en = 1'b0;
   logic [CFG_W-1:0]       csr_wr_data = '0;

   // predictor state
   logic [CFG_W-1:0] ordered_cfg = '0;
   ch_state_type     chan_st [NUM_VCS];
   logic [OFS_W-1:0] alloc_ptr [NUM_VNETS_DEF];
   logic [VC_IDX_W-1:0] sched_ptr = '0;

   vc_req_type pend_q[$];
   vc_rsp_type rsp_due_q[$];
   vc_req_type cur_req;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int n_errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_selected = 0;
   int n_flagged = 0;
   int n_settings = 0;
   int cycle_count = 0;

   ni_vc_allocate_and_schedule dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < NUM_VCS; i++) chan_st[i] = CH_IDLE;
      for (int i = 0; i < NUM_VNETS_DEF; i++) alloc_ptr[i] = '0;
   end

   function automatic vc_rsp_type predict_response(vc_req_type r);
      vc_rsp_type          res;
      logic [VC_IDX_W-1:0] vc;
      logic [OFS_W-1:0]    ofs;
      bit                  ordered;
      ch_state_type        need;
      ch_state_type        nxt;
      res = '{chosen_vc: '0, found: 1'b0, bad_state: 1'b0};
      case (r.kind)
         REQ_ALLOC: begin
            // an ordered vnet only ever tries its first vc
            ordered = ordered_cfg[r.vnet];
            for (int i = 0; i < (ordered ? 1 : VCS_PER_VNET_DEF) && !res.found; i++) begin
               ofs = ordered ? '0 : alloc_ptr[r.vnet];
               alloc_ptr[r.vnet] = ordered ? '0 : ofs + 1'b1;
               vc = {r.vnet, ofs};
               if (chan_st[vc] == CH_IDLE) begin
                  chan_st[vc] = CH_WAIT;
                  res.chosen_vc = vc;
                  res.found = 1'b1;
               end
            end
         end
         REQ_GRANT, REQ_RELEASE: begin
            if (r.kind == REQ_GRANT) begin
               need = CH_WAIT;
               nxt = CH_ACTIVE;
            end else begin
               need = CH_ACTIVE;
               nxt = CH_IDLE;
            end
            if (chan_st[r.vc_index] == need) chan_st[r.vc_index] = nxt;
            else res.bad_state = 1'b1;
         end
         default: begin
            // search starts one past the old pointer
            vc = sched_ptr;
            sched_ptr = sched_ptr + 1'b1;
            for (int i = 0; i < NUM_VCS && !res.found; i++) begin
               vc = vc + 1'b1;
               if (r.ready_mask[vc] && r.credit_mask[vc] && chan_st[vc] == CH_ACTIVE) begin
                  res.chosen_vc = vc;
                  res.found = 1'b1;
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [MASK_W-1:0] random_mask();
      case ($urandom_range(3))
         0: return MASK_W'($urandom);
         1: return '1;
         2: return MASK_W'($urandom | $urandom);
         default: return MASK_W'($urandom & $urandom);
      endcase
   endfunction

   function automatic vc_req_type random_req();
      vc_req_type r;
      r.kind = req_kind_type'($urandom_range(3));
      r.vnet = VNET_IN_W'($urandom);
      r.vc_index = VC_IDX_W'($urandom);
      r.ready_mask = MASK_W'($urandom);
      r.credit_mask = MASK_W'($urandom);
      r.hold = 1'b0;
      return r;
   endfunction

   task automatic queue_req(input req_kind_type kind, input logic [VNET_IN_W-1:0] vnet,
                            input logic [VC_IDX_W-1:0] vc, input logic [MASK_W-1:0] ready,
                            input logic [MASK_W-1:0] credit, input bit hold = 1'b0);
      vc_req_type r;
      r = '{kind: kind, vnet: vnet, vc_index: vc, ready_mask: ready,
            credit_mask: credit, hold: hold};
      pend_q = {pend_q, r};
   endtask

   // wait until everything sent has been answered, then let the pipeline settle
   task automatic wait_idle();
      do @(negedge clock); while (pend_q.size() != 0 || req_tvalid || rsp_due_q.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_ordered(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ordered_cfg = value;
      n_settings++;
   endtask

   task automatic flag_mismatch(input string what, input int want_v, input int got_v);
      if (n_errors < MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      n_errors++;
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      vc_rsp_type due;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due = predict_response(cur_req);
            rsp_due_q = {rsp_due_q, due};
            n_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pend_q.size() != 0 && !(pend_q[0].hold && rsp_due_q.size() != 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               cur_req = pend_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_req.kind;
               req_tdata <= REQ_TDATA_W'({cur_req.credit_mask, cur_req.ready_mask,
                                          cur_req.vc_index, cur_req.vnet});
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      vc_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_due_q.size() == 0) begin
               flag_mismatch("unexpected response, chosen_vc", -1, rsp_tdata);
            end else begin
               want = rsp_due_q.pop_front();
               n_checked++;
               n_selected += want.found;
               n_flagged += want.bad_state;
               if (rsp_tdata !== RSP_TDATA_W'(want.chosen_vc))
                  flag_mismatch("chosen_vc", want.chosen_vc, rsp_tdata);
               if (rsp_tuser[0] !== want.found)
                  flag_mismatch("found", want.found, rsp_tuser[0]);
               if (rsp_tuser[1] !== want.bad_state)
                  flag_mismatch("bad_state", want.bad_state, rsp_tuser[1]);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      vc_req_type       r;
      int               n;
      int               pick;
      logic [1:0]       v;
      logic [CFG_W-1:0] cfg_val;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 12;
      recv_idle_pct = 45;
      write_ordered(4'h0);

      // fill vnet 0, then one more allocate finds nothing
      repeat (5) queue_req(REQ_ALLOC, 2'd0, 4'd0, 16'h0000, 16'h0000);
      queue_req(REQ_GRANT, 2'd0, 4'd0, 16'hFFFF, 16'h0000);
      queue_req(REQ_GRANT, 2'd0, 4'd0, 16'h0000, 16'hFFFF);   // already active
      queue_req(REQ_RELEASE, 2'd3, 4'd1, 16'hFFFF, 16'hFFFF); // still waiting
      queue_req(REQ_GRANT, 2'd1, 4'd1, 16'h5555, 16'hAAAA);
      queue_req(REQ_SCHED, 2'd3, 4'd15, 16'hFFFF, 16'hFFFF);
      queue_req(REQ_SCHED, 2'd0, 4'd0, 16'hFFFF, 16'h0000);
      queue_req(REQ_SCHED, 2'd0, 4'd0, 16'h0000, 16'hFFFF);
      queue_req(REQ_RELEASE, 2'd0, 4'd0, 16'h0000, 16'h0000, 1'b1);
      queue_req(REQ_RELEASE, 2'd0, 4'd0, 16'h0000, 16'h0000); // now idle
      queue_req(REQ_ALLOC, 2'd3, 4'd0, 16'h0000, 16'h0000);
      queue_req(REQ_GRANT, 2'd0, 4'd15, 16'h0000, 16'h0000);  // idle vc
      queue_req(REQ_ALLOC, 2'd3, 4'd0, 16'h0000, 16'h0000);
      queue_req(REQ_GRANT, 2'd3, 4'd12, 16'h0000, 16'h0000);
      queue_req(REQ_SCHED, 2'd0, 4'd0, 16'h1000, 16'h1000);
      wait_idle();

      // every vnet ordered
      write_ordered(4'hF);
      queue_req(REQ_ALLOC, 2'd1, 4'd0, 16'h0000, 16'h0000);
      queue_req(REQ_ALLOC, 2'd1, 4'd0, 16'h0000, 16'h0000);
      queue_req(REQ_ALLOC, 2'd0, 4'd0, 16'h0000, 16'h0000);
      queue_req(REQ_ALLOC, 2'd2, 4'd0, 16'h0000, 16'h0000);
      queue_req(REQ_GRANT, 2'd1, 4'd4, 16'h0000, 16'h0000);
      queue_req(REQ_SCHED, 2'd1, 4'd4, 16'h0010, 16'hFFFF);

      for (int c = 0; c < NUM_CHUNKS; c++) begin
         wait_idle();
         case (c)
            0: cfg_val = 4'h0;
            1: cfg_val = 4'h5;
            2: cfg_val = 4'hF;
            3: cfg_val = 4'hA;
            default: cfg_val = CFG_W'($urandom);
         endcase
         write_ordered(cfg_val);
         if (c < 2) begin
            send_idle_pct = 12;
            recv_idle_pct = 45;
         end else if (c < 4) begin
            send_idle_pct = 45;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         n = 0;
         while (n < CHUNK_ITEMS) begin
            r = random_req();
            r.hold = ($urandom_range(79) == 0);
            pick = $urandom_range(99);
            if (pick < 35) begin
               // allocate followed by a grant aimed at the same vnet
               r.kind = REQ_ALLOC;
               pend_q = {pend_q, r};
               v = r.vnet;
               r = random_req();
               r.kind = REQ_GRANT;
               r.vc_index = ordered_cfg[v] ? {v, 2'b00} : {v, 2'($urandom)};
               pend_q = {pend_q, r};
               n += 2;
            end else begin
               if (pick < 65) begin
                  r.kind = REQ_SCHED;
                  r.ready_mask = random_mask();
                  r.credit_mask = random_mask();
               end else if (pick < 80) begin
                  r.kind = REQ_RELEASE;
               end else if (pick < 90) begin
                  r.kind = REQ_GRANT;
               end
               pend_q = {pend_q, r};
               n++;
            end
         end
      end
      wait_idle();

      $display("sent %0d requests over %0d ordered-vnet settings with varied stalls",
               n_sent, n_settings);
      $display("checked %0d responses: %0d selected a vc, %0d flagged a bad state",
               n_checked, n_selected, n_flagged);
      if (n_errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
